/* hw/rtl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the LED frame driver
// Operation codes, bit phases, register indexes and reset values.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // default chain length
  localparam int NUM_LEDS_DEF = 8;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // phases of one serial bit
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_DATA = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_HIGH = 2'd0;
  localparam logic [1:0] REG_DATA = 2'd1;
  localparam logic [1:0] REG_LOW  = 2'd2;

  // register reset values
  localparam logic [7:0] HIGH_TICKS_RST = 8'd8;
  localparam logic [7:0] DATA_TICKS_RST = 8'd16;
  localparam logic [7:0] LOW_TICKS_RST  = 8'd16;

  // bytes go out MSB first
  localparam logic [2:0] BIT_FIRST = 3'd7;

  // colors per LED row: green, red, blue
  localparam logic [1:0] COLOR_GREEN = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

endpackage

/* hw/rtl/ws2812_frame_driver.sv */
// Throughput: one item per cycle while the skid register is empty; a two-deep
//   output (result plus skid register) lets items enter while a result waits.
// Reset: synchronous, active high; clears control state and the per-row valid
//   bits (the whole color store reads as zero at once) and presets timing registers.
// ----------------------------------------------------------------------------
// ws2812_frame_driver: color store and single-wire serial LED frame driver
// Stores green/red/blue per LED in reversed slot order and, on a start
// command, shifts the whole store out MSB first, one tick item per step,
// each bit as a high phase, a data phase and a low phase.
// ----------------------------------------------------------------------------
module ws2812_frame_driver
  import wsfd_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  position,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        busy_res,
  output logic        frame_done,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(NUM_LEDS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] high_ticks;
  logic [7:0] data_ticks;
  logic [7:0] low_ticks;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_ticks <= HIGH_TICKS_RST;
      data_ticks <= DATA_TICKS_RST;
      low_ticks  <= LOW_TICKS_RST;
    end else if (cfg_wr) begin
      // writes past the last register are dropped
      case (paddr[3:2])
        REG_HIGH: high_ticks <= pwdata[7:0];
        REG_DATA: data_ticks <= pwdata[7:0];
        REG_LOW:  low_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HIGH: prdata = {24'd0, high_ticks};
      REG_DATA: prdata = {24'd0, data_ticks};
      REG_LOW:  prdata = {24'd0, low_ticks};
      default:  prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: result register plus one skid register. The input stalls
  // only while the skid register holds a result.
  // --------------------------------------------------------------------------
  logic accept;
  logic out_free;
  logic skid_valid;
  logic skid_line, skid_busy, skid_done;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // Transmit state
  // --------------------------------------------------------------------------
  logic             sending,     sending_next;
  logic [IDX_W-1:0] led_index,   led_next;
  logic [1:0]       color_sel,   color_next;
  logic [2:0]       bit_index,   bit_next;
  phase_t           bit_phase,   phase_next;
  logic [7:0]       phase_count, count_next;
  logic             line_reg,    line_next;
  logic             done_next;

  // color store: one 24-bit row per LED slot, {green, red, blue}
  logic [23:0]         store [NUM_LEDS];
  logic [NUM_LEDS-1:0] row_valid;
  logic [23:0]         rd_row;
  logic                rd_ok;

  logic             pos_ok;
  logic [6:0]       slot_wide;
  logic [IDX_W-1:0] slot;
  logic             wr_en;
  logic [7:0]       cur_byte;
  logic [7:0]       phase_len;
  logic [8:0]       cnt;

  assign pos_ok    = {4'd0, position} < 7'(NUM_LEDS);
  assign slot_wide = 7'(NUM_LEDS - 1) - {4'd0, position};
  assign slot      = slot_wide[IDX_W-1:0];

  // byte under transmission from the registered row
  always_comb begin
    case (color_sel)
      COLOR_GREEN: cur_byte = rd_row[23:16];
      COLOR_RED:   cur_byte = rd_row[15:8];
      default:     cur_byte = rd_row[7:0];
    endcase
    if (!rd_ok) begin
      cur_byte = 8'd0;
    end
  end

  always_comb begin
    case (bit_phase)
      PH_HIGH: phase_len = high_ticks;
      PH_DATA: phase_len = data_ticks;
      default: phase_len = low_ticks;
    endcase
  end

  assign cnt = {1'b0, phase_count} + 9'd1;

  // next state of the frame sequencer for the accepted item
  always_comb begin
    sending_next = sending;
    led_next     = led_index;
    color_next   = color_sel;
    bit_next     = bit_index;
    phase_next   = bit_phase;
    count_next   = phase_count;
    line_next    = line_reg;
    done_next    = 1'b0;
    wr_en        = 1'b0;
    if (accept) begin
      case (op_t'(op))
        OP_WRITE: begin
          // drop writes during a frame and out-of-range positions
          wr_en = !sending && pos_ok;
        end
        OP_START: begin
          if (!sending) begin
            sending_next = 1'b1;
            led_next     = '0;
            color_next   = COLOR_GREEN;
            bit_next     = BIT_FIRST;
            phase_next   = PH_HIGH;
            count_next   = 8'd0;
          end
        end
        OP_TICK: begin
          if (sending) begin
            case (bit_phase)
              PH_HIGH: line_next = 1'b1;
              PH_DATA: line_next = cur_byte[bit_index];
              default: line_next = 1'b0;
            endcase
            // a zero length ends the phase after one tick
            if (cnt >= {1'b0, phase_len}) begin
              count_next = 8'd0;
              case (bit_phase)
                PH_HIGH: phase_next = PH_DATA;
                PH_DATA: phase_next = PH_LOW;
                default: begin
                  phase_next = PH_HIGH;
                  if (bit_index != 3'd0) begin
                    bit_next = bit_index - 3'd1;
                  end else begin
                    bit_next = BIT_FIRST;
                    if (color_sel != COLOR_BLUE) begin
                      color_next = color_sel + 2'd1;
                    end else if (led_index != LAST_LED) begin
                      color_next = COLOR_GREEN;
                      led_next   = led_index + IDX_W'(1);
                    end else begin
                      // last bit of the frame
                      color_next   = COLOR_GREEN;
                      led_next     = '0;
                      sending_next = 1'b0;
                      done_next    = 1'b1;
                    end
                  end
                end
              endcase
            end else begin
              count_next = cnt[7:0];
            end
          end else begin
            line_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending     <= 1'b0;
      led_index   <= '0;
      color_sel   <= COLOR_GREEN;
      bit_index   <= BIT_FIRST;
      bit_phase   <= PH_HIGH;
      phase_count <= 8'd0;
      line_reg    <= 1'b0;
    end else begin
      sending     <= sending_next;
      led_index   <= led_next;
      color_sel   <= color_next;
      bit_index   <= bit_next;
      bit_phase   <= phase_next;
      phase_count <= count_next;
      line_reg    <= line_next;
    end
  end

  // --------------------------------------------------------------------------
  // Store: one write port, one registered read port that tracks the next
  // LED index, so the row of the current LED is always ready for a tick.
  // Writes only happen while idle, when the read address sits at LED zero
  // and a start needs at least one more item before the first tick.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[slot] <= {green, red, blue};
    end
    rd_row <= store[led_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[slot] <= 1'b1;
      end
      rd_ok <= row_valid[led_next];
    end
  end

  // --------------------------------------------------------------------------
  // Result register and skid register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid register first; no item enters meanwhile
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        line_level <= skid_line;
        busy_res   <= skid_busy;
        frame_done <= skid_done;
      end
    end else if (accept) begin
      if (out_free) begin
        line_level <= line_next;
        busy_res   <= sending_next;
        frame_done <= done_next;
      end else begin
        skid_line <= line_next;
        skid_busy <= sending_next;
        skid_done <= done_next;
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LED frame driver
// Drives write, start, tick and spare items through the valid/stall channel
// and programs the phase timing over the register port. An in-bench color
// store and waveform tracker predicts each result, and every result is
// compared against it in order.
// ----------------------------------------------------------------------------
module tb;
  import wsfd_pkg::*;

  localparam int NUM_LEDS     = NUM_LEDS_DEF;
  localparam int STORE_BYTES  = 3 * NUM_LEDS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_CAP    = 100;

  // op 3 has no meaning in the block; it must pass as an idle item
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_item_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic done;
  } led_result_t;

  typedef struct {
    led_item_t   item;
    bit          typed;
    led_result_t res;
  } step_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [2:0]  position;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        out_valid;
  logic        out_stall;
  logic        line_level;
  logic        busy_res;
  logic        frame_done;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ws2812_frame_driver #(.NUM_LEDS(NUM_LEDS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .position   (position),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_level (line_level),
    .busy_res   (busy_res),
    .frame_done (frame_done),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predicted driver state: color store, waveform position, timing
  logic [7:0] store [STORE_BYTES];
  int         byte_idx;
  logic [2:0] bit_idx;
  phase_t     phase;
  logic [7:0] pcount;
  logic       tx_on;
  logic       line_q;
  logic [7:0] cfg_high;
  logic [7:0] cfg_data;
  logic [7:0] cfg_low;

  led_result_t pending_results[$];
  step_row_t   directed_rows[$];

  int cycles;
  int errors;
  int n_items;
  int n_results;
  int n_frames;
  int n_reg_checks;
  int send_idle;
  int stall_idle;
  bit hold_go;
  logic hold_off;

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: cycle limit of %0d reached, %0d results pending",
               CYCLE_LIMIT, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall: random stalls plus the long hold-off window
  always @(posedge clk) begin
    out_stall <= hold_off || (($urandom_range(99)) < stall_idle);
  end

  // long receiver hold-off, counted here so the sender keeps pushing items
  // and the block's output buffer fills until it stalls the input
  initial begin : receiver_hold
    hold_off <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // print one mismatch line (up to a cap) and count it
  task automatic report(input string what, input int want, input int got);
    errors++;
    if (errors <= PRINT_CAP)
      $display("tb: mismatch at cycle %0d, %s: expected %0d got %0d",
               cycles, what, want, got);
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    led_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (frame_done) n_frames++;
      if (pending_results.size() == 0) begin
        report("result with no item pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (line_level !== want.line_level)
          report("line_level", want.line_level, line_level);
        if (busy_res !== want.busy)
          report("busy_res", want.busy, busy_res);
        if (frame_done !== want.done)
          report("frame_done", want.done, frame_done);
      end
    end
  end

  task automatic reset_model();
    for (int i = 0; i < STORE_BYTES; i++) store[i] = 8'd0;
    byte_idx = 0;
    bit_idx  = BIT_FIRST;
    phase    = PH_HIGH;
    pcount   = 8'd0;
    tx_on    = 1'b0;
    line_q   = 1'b0;
    cfg_high = HIGH_TICKS_RST;
    cfg_data = DATA_TICKS_RST;
    cfg_low  = LOW_TICKS_RST;
  endtask

  // advance the predicted driver by one item and return its result
  function automatic led_result_t frame_step(input led_item_t it);
    led_result_t r;
    logic [7:0]  cur;
    logic [7:0]  len;
    logic [8:0]  cnt;
    int          slot;
    r.done = 1'b0;
    case (it.op)
      OP_WRITE: begin
        // positions past the chain end are dropped; a 3-bit field cannot
        // reach that with eight LEDs
        if (!tx_on && int'(it.position) < NUM_LEDS) begin
          slot = NUM_LEDS - 1 - int'(it.position);
          store[slot * 3 + COLOR_GREEN] = it.green;
          store[slot * 3 + COLOR_RED]   = it.red;
          store[slot * 3 + COLOR_BLUE]  = it.blue;
        end
      end
      OP_START: begin
        if (!tx_on) begin
          tx_on    = 1'b1;
          byte_idx = 0;
          bit_idx  = BIT_FIRST;
          phase    = PH_HIGH;
          pcount   = 8'd0;
        end
      end
      OP_TICK: begin
        if (tx_on) begin
          cur = store[byte_idx];
          case (phase)
            PH_HIGH: begin
              len    = cfg_high;
              line_q = 1'b1;
            end
            PH_DATA: begin
              len    = cfg_data;
              line_q = cur[bit_idx];
            end
            default: begin
              len    = cfg_low;
              line_q = 1'b0;
            end
          endcase
          // a length of zero ends the phase after one tick, like a length of one
          cnt = {1'b0, pcount} + 9'd1;
          if (cnt >= {1'b0, len}) begin
            pcount = 8'd0;
            if (phase == PH_HIGH) begin
              phase = PH_DATA;
            end else if (phase == PH_DATA) begin
              phase = PH_LOW;
            end else begin
              phase = PH_HIGH;
              if (bit_idx != 3'd0) begin
                bit_idx = bit_idx - 3'd1;
              end else begin
                bit_idx  = BIT_FIRST;
                byte_idx = byte_idx + 1;
                if (byte_idx >= STORE_BYTES) begin
                  byte_idx = 0;
                  tx_on    = 1'b0;
                  r.done   = 1'b1;
                end
              end
            end
          end else begin
            pcount = cnt[7:0];
          end
        end else begin
          line_q = 1'b0;
        end
      end
      default: ;
    endcase
    r.line_level = line_q;
    r.busy       = tx_on;
    return r;
  endfunction

  // offer one item with a random lead gap; predict it once accepted
  task automatic offer(input led_item_t it, input bit typed, input led_result_t typed_res);
    led_result_t r;
    while (($urandom_range(99)) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= it.op;
    position <= it.position;
    red      <= it.red;
    green    <= it.green;
    blue     <= it.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = frame_step(it);
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  // drop valid and let every pending result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register read over the config port, checked against the expected value
  task automatic check_reg(input logic [1:0] idx, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    n_reg_checks++;
    if (prdata !== {24'd0, want}) report("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write over the config port, then read it back; the upper
  // data bits carry junk that the block must drop
  task automatic set_timing(input logic [1:0] idx, input logic [7:0] value);
    logic [23:0] junk;
    junk    = 24'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HIGH: cfg_high = value;
      REG_DATA: cfg_data = value;
      default:  cfg_low  = value;
    endcase
    @(posedge clk);
    check_reg(idx, value);
  endtask

  task automatic add_row(input logic [1:0] o, input logic [2:0] pos, input logic [7:0] r,
                         input logic [7:0] g, input logic [7:0] b, input bit typed,
                         input logic l, input logic bz, input logic d);
    step_row_t row;
    row.item  = '{op: o, position: pos, red: r, green: g, blue: b};
    row.typed = typed;
    row.res   = '{line_level: l, busy: bz, done: d};
    directed_rows.push_back(row);
  endtask

  // one random phase: program the timing while quiet, then stream items
  task automatic run_phase(input logic [7:0] h, input logic [7:0] d, input logic [7:0] l,
                           input int count, input int idle_pct);
    led_item_t it;
    int        pick;
    drain();
    set_timing(REG_HIGH, h);
    set_timing(REG_DATA, d);
    set_timing(REG_LOW, l);
    send_idle  = idle_pct;
    stall_idle = idle_pct;
    // start the long receiver hold-off once items are flowing again
    hold_go    = 1'b1;
    for (int n = 0; n < count; n++) begin
      pick        = $urandom_range(99);
      it.position = 3'($urandom_range(7));
      it.red      = 8'($urandom);
      it.green    = 8'($urandom);
      it.blue     = 8'($urandom);
      // idle: mostly load colors and start a frame; busy: mostly ticks,
      // with a few writes, starts and spare ops that must be dropped
      if (!tx_on) begin
        if (pick < 40)      it.op = OP_WRITE;
        else if (pick < 65) it.op = OP_START;
        else if (pick < 90) it.op = OP_TICK;
        else                it.op = OP_SPARE;
      end else begin
        if (pick < 3)       it.op = OP_WRITE;
        else if (pick < 5)  it.op = OP_START;
        else if (pick < 7)  it.op = OP_SPARE;
        else                it.op = OP_TICK;
      end
      offer(it, 1'b0, '0);
    end
  endtask

  initial begin : main_seq
    step_row_t row;
    cycles       = 0;
    errors       = 0;
    n_items      = 0;
    n_results    = 0;
    n_frames     = 0;
    n_reg_checks = 0;
    hold_go      = 1'b0;
    send_idle    = 13;
    stall_idle   = 13;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= OP_WRITE;
    position <= 3'd0;
    red      <= 8'd0;
    green    <= 8'd0;
    blue     <= 8'd0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 4'd0;
    pwdata   <= 32'd0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // timing registers come up at their reset values
    check_reg(REG_HIGH, HIGH_TICKS_RST);
    check_reg(REG_DATA, DATA_TICKS_RST);
    check_reg(REG_LOW, LOW_TICKS_RST);

    // directed: idle items, color extremes, start, and dropped busy items
    add_row(OP_TICK,  3'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_SPARE, 3'd5, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 3'd0, 8'hff, 8'h00, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 3'd7, 8'h00, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 3'd3, 8'h80, 8'h01, 8'h7f, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 3'd0, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 3'd6, 8'haa, 8'h55, 8'h0f, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(OP_START, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(OP_TICK,  3'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
    add_row(OP_WRITE, 3'd7, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 1'b1, 1'b0);
    add_row(OP_START, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
    add_row(OP_SPARE, 3'd7, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1, 1'b0);
    // run through the rest of the high phase into the data phase
    for (int k = 0; k < 12; k++)
      add_row(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    while (directed_rows.size() != 0) begin
      row = directed_rows.pop_front();
      offer(row.item, row.typed, row.res);
    end

    // random phases; the first one changes timing in the middle of the
    // frame left running above, shrinking a phase below its current count
    run_phase(8'd1, 8'd1, 8'd1, 400, 13);
    // long stretch with no idling on either side; zero counts act as one
    run_phase(8'd0, 8'd0, 8'd0, 400, 0);
    run_phase(8'd3, 8'd1, 8'd2, 250, 13);
    run_phase(8'd255, 8'd255, 8'd255, 100, 13);
    run_phase(8'd1, 8'd255, 8'd1, 100, 13);

    drain();
    $display("tb: %0d items sent, %0d results checked, %0d frames completed",
             n_items, n_results, n_frames);
    $display("tb: %0d register readbacks, timing from 0 to 255 ticks per phase",
             n_reg_checks);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("tb: %0d mismatches, %0d results never arrived",
               errors, pending_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
